>>> rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg - shared definitions for the epoch calendar converter
// Pipeline stage indexes, divider reciprocals, calendar tables and the
// stage control type used between the control and datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

   // Pipeline stage indexes, stage E is the output register
   localparam int STAGES = 5;
   localparam int ST_A   = 0;
   localparam int ST_B   = 1;
   localparam int ST_C   = 2;
   localparam int ST_D   = 3;
   localparam int ST_E   = 4;

   // Calendar constants
   localparam logic [16:0] DAY_SECONDS   = 17'd86400;
   localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
   localparam logic [10:0] MINS_PER_DAY  = 11'd1440;
   localparam logic [5:0]  SIXTY         = 6'd60;
   localparam logic [7:0]  EPOCH_YEAR    = 8'd70;
   localparam logic [7:0]  LAST_YEAR     = 8'd138;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;
   localparam logic [4:0]  LAST_HOUR     = 5'd23;
   localparam logic [5:0]  LAST_MINUTE   = 6'd59;

   // Reciprocals for exact division by constants: q = (x * RECIP) >> SHIFT
   // Seconds to days: (secs >> 7) / 675, 25-bit dividend
   localparam int          DAY_SHIFT  = 35;
   localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
   // Days to four-year groups: days / 1461, 16-bit dividend
   localparam int          QUAD_SHIFT = 27;
   localparam logic [16:0] QUAD_RECIP = 17'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);
   // Time of day to minutes: (tod >> 2) / 15, 15-bit dividend
   localparam int          MIN_SHIFT  = 19;
   localparam logic [15:0] MIN_RECIP  = 16'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);
   // Time of day to hours: (tod >> 4) / 225, 13-bit dividend
   localparam int          HOUR_SHIFT = 21;
   localparam logic [13:0] HOUR_RECIP = 14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);

   // Stage load enables from the control module
   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

   // Length of a month, zero for codes past December
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
      logic [4:0] len;
      unique case (mon)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         4'd1:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // Day of year on which a month starts, zero for codes past December
   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
      logic [8:0] start;
      unique case (mon)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd59;
         4'd3:    start = 9'd90;
         4'd4:    start = 9'd120;
         4'd5:    start = 9'd151;
         4'd6:    start = 9'd181;
         4'd7:    start = 9'd212;
         4'd8:    start = 9'd243;
         4'd9:    start = 9'd273;
         4'd10:   start = 9'd304;
         4'd11:   start = 9'd334;
         default: start = 9'd0;
      endcase
      if (leap && (mon >= 4'd2) && (mon <= LAST_MONTH)) begin
         start = start + 9'd1;
      end
      return start;
   endfunction

   // First day of each year within a four-year group, the third year is leap
   function automatic logic [10:0] year_offset(input logic [1:0] yr);
      logic [10:0] offs;
      unique case (yr)
         2'd0: offs = 11'd0;
         2'd1: offs = 11'd365;
         2'd2: offs = 11'd730;
         2'd3: offs = 11'd1096;
      endcase
      return offs;
   endfunction

   // Remainder by 7: octal digits carry weight 1 modulo 7
   function automatic logic [2:0] mod7(input logic [16:0] value);
      logic [17:0] padded;
      logic [5:0]  digit_sum;
      logic [3:0]  fold;
      padded    = {1'b0, value};
      digit_sum = '0;
      for (int i = 0; i < 6; i++) begin
         digit_sum = digit_sum + 6'(padded[3*i +: 3]);
      end
      fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
      if (fold >= 4'd7) begin
         fold = fold - 4'd7;
      end
      return fold[2:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/ecc_if.sv
// ----------------------------------------------------------------------------
// ecc_if - request and response channels of the epoch calendar converter
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] epoch_seconds;
   logic [7:0]  year_in;
   logic [3:0]  month_in;
   logic [4:0]  day_in;
   logic [4:0]  hour_in;
   logic [5:0]  minute_in;

   modport source (
      output valid, func, epoch_seconds, year_in, month_in, day_in, hour_in, minute_in,
      input  ready
   );
   modport sink (
      input  valid, func, epoch_seconds, year_in, month_in, day_in, hour_in, minute_in,
      output ready
   );
endinterface

interface ecc_rsp_if;
   logic        valid;
   logic        ready;
   logic        error;
   logic [31:0] epoch_out;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [4:0]  day_of_month;
   logic [3:0]  month;
   logic [7:0]  year;
   logic [2:0]  weekday;
   logic [8:0]  day_of_year;

   modport source (
      output valid, error, epoch_out, second, minute, hour, day_of_month, month, year,
             weekday, day_of_year,
      input  ready
   );
   modport sink (
      input  valid, error, epoch_out, second, minute, hour, day_of_month, month, year,
             weekday, day_of_year,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/ecc_ctrl.sv
// ----------------------------------------------------------------------------
// ecc_ctrl - pipeline valid chain and stage load enables
// Each stage loads when it is empty or the stage after it loads, so bubbles
// close up and a stalled output holds each full stage with no bubble after it.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_func,
   input  logic                   out_ready,
   output logic                   in_ready,
   output logic                   out_valid,
   output logic                   out_func,
   output ecc_pkg::pipe_ctrl_type ctrl
);

   logic [ecc_pkg::STAGES-1:0] valid_ff, valid_in;
   logic [ecc_pkg::STAGES-1:0] func_ff, func_in;
   logic [ecc_pkg::STAGES-1:0] load;
   logic [ecc_pkg::STAGES-1:0] prev_valid, prev_func;

   // Derive load enables from the output back to the input
   always_comb begin
      load[ecc_pkg::STAGES-1] = !valid_ff[ecc_pkg::STAGES-1] || out_ready;
      for (int k = ecc_pkg::STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // Advance valid and func bits into every loading stage
   assign prev_valid = {valid_ff[ecc_pkg::STAGES-2:0], in_valid};
   assign prev_func  = {func_ff[ecc_pkg::STAGES-2:0], in_func};

   always_comb begin
      for (int k = 0; k < ecc_pkg::STAGES; k++) begin
         valid_in[k] = load[k] ? prev_valid[k] : valid_ff[k];
         func_in[k]  = load[k] ? prev_func[k]  : func_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
   end

   assign in_ready  = load[ecc_pkg::ST_A];
   assign out_valid = valid_ff[ecc_pkg::STAGES-1];
   assign out_func  = func_ff[ecc_pkg::STAGES-1];
   assign ctrl.load = load;

endmodule

`default_nettype wire

>>> rtl/ecc_split.sv
// ----------------------------------------------------------------------------
// ecc_split - seconds count to calendar fields datapath
// Five stages: day division, time of day and group division, minute and
// hour division, year within group, month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_split (
   input  logic                   clock,
   input  ecc_pkg::pipe_ctrl_type ctrl,
   input  logic [31:0]            epoch_seconds,
   output logic [5:0]             second,
   output logic [5:0]             minute,
   output logic [4:0]             hour,
   output logic [4:0]             day_of_month,
   output logic [3:0]             month,
   output logic [7:0]             year,
   output logic [2:0]             weekday,
   output logic [8:0]             day_of_year
);

   // Stage A: multiply by the day reciprocal
   logic [50:0] day_prod_ff, day_prod_in;
   logic [16:0] secs_lo_ff;

   assign day_prod_in = {26'd0, epoch_seconds[31:7]} * {25'd0, ecc_pkg::DAY_RECIP};

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_A]) begin
         day_prod_ff <= day_prod_in;
         secs_lo_ff  <= epoch_seconds[16:0];
      end
   end

   // Stage B: time of day, four-year group and weekday
   logic [15:0] days_b;
   logic [32:0] day_secs, quad_prod;
   logic [15:0] days_ff;
   logic [16:0] tod_ff, tod_in;
   logic [5:0]  quad_b_ff, quad_b_in;
   logic [2:0]  wk_b_ff, wk_b_in;

   assign days_b    = day_prod_ff[50:35];
   assign day_secs  = {17'd0, days_b} * {16'd0, ecc_pkg::DAY_SECONDS};
   assign tod_in    = secs_lo_ff - day_secs[16:0];
   assign quad_prod = {17'd0, days_b} * {16'd0, ecc_pkg::QUAD_RECIP};
   assign quad_b_in = quad_prod[32:27];
   assign wk_b_in   = ecc_pkg::mod7({1'b0, days_b} + 17'd4);

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_B]) begin
         days_ff   <= days_b;
         tod_ff    <= tod_in;
         quad_b_ff <= quad_b_in;
         wk_b_ff   <= wk_b_in;
      end
   end

   // Stage C: day within group, minutes and hours of the day
   logic [15:0] quad_days;
   logic [30:0] min_prod;
   logic [26:0] hour_prod;
   logic [15:0] rem_full;
   logic [10:0] rem_ff, rem_in;
   logic [10:0] mins_ff, mins_in;
   logic [4:0]  hour_c_ff, hour_c_in;
   logic [5:0]  tod_c_ff;
   logic [5:0]  quad_c_ff;
   logic [2:0]  wk_c_ff;

   assign quad_days = {10'd0, quad_b_ff} * {5'd0, ecc_pkg::DAYS_PER_QUAD};
   assign rem_full  = days_ff - quad_days;
   assign rem_in    = rem_full[10:0];
   assign min_prod  = {16'd0, tod_ff[16:2]} * {15'd0, ecc_pkg::MIN_RECIP};
   assign mins_in   = min_prod[29:19];
   assign hour_prod = {14'd0, tod_ff[16:4]} * {13'd0, ecc_pkg::HOUR_RECIP};
   assign hour_c_in = hour_prod[25:21];

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_C]) begin
         rem_ff    <= rem_in;
         mins_ff   <= mins_in;
         hour_c_ff <= hour_c_in;
         tod_c_ff  <= tod_ff[5:0];
         quad_c_ff <= quad_b_ff;
         wk_c_ff   <= wk_b_ff;
      end
   end

   // Stage D: seconds, minute of hour, year within group
   logic [16:0] mins_secs;
   logic [10:0] hour_mins;
   logic [1:0]  offs;
   logic [10:0] rem_y_full;
   logic [5:0]  sec_d_ff, sec_d_in;
   logic [5:0]  min_d_ff, min_d_in;
   logic [4:0]  hour_d_ff;
   logic [2:0]  wk_d_ff;
   logic [7:0]  year_d_ff, year_d_in;
   logic        leap_ff, leap_in;
   logic [8:0]  doy_d_ff, doy_d_in;

   assign mins_secs = {6'd0, mins_ff} * {11'd0, ecc_pkg::SIXTY};
   assign hour_mins = {6'd0, hour_c_ff} * {5'd0, ecc_pkg::SIXTY};
   assign sec_d_in  = tod_c_ff - mins_secs[5:0];
   assign min_d_in  = mins_ff[5:0] - hour_mins[5:0];

   always_comb begin
      offs = 2'd0;
      if (rem_ff >= 11'd365) begin
         offs = 2'd1;
      end
      if (rem_ff >= 11'd730) begin
         offs = 2'd2;
      end
      if (rem_ff >= 11'd1096) begin
         offs = 2'd3;
      end
   end

   assign rem_y_full = rem_ff - ecc_pkg::year_offset(offs);
   assign doy_d_in   = rem_y_full[8:0];
   assign leap_in    = (offs == 2'd2);
   assign year_d_in  = ecc_pkg::EPOCH_YEAR + {quad_c_ff, 2'b00} + {6'd0, offs};

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_D]) begin
         sec_d_ff  <= sec_d_in;
         min_d_ff  <= min_d_in;
         hour_d_ff <= hour_c_ff;
         wk_d_ff   <= wk_c_ff;
         year_d_ff <= year_d_in;
         leap_ff   <= leap_in;
         doy_d_ff  <= doy_d_in;
      end
   end

   // Stage E: month and day of month
   logic [3:0] mon_in;
   logic [8:0] day_full;
   logic [5:0] sec_e_ff;
   logic [5:0] min_e_ff;
   logic [4:0] hour_e_ff;
   logic [4:0] mday_e_ff;
   logic [3:0] mon_e_ff;
   logic [7:0] year_e_ff;
   logic [2:0] wk_e_ff;
   logic [8:0] doy_e_ff;

   // Count month starts at or before the day of year
   always_comb begin
      mon_in = 4'd0;
      for (int m = 1; m <= 11; m++) begin
         if (doy_d_ff >= ecc_pkg::month_start(leap_ff, 4'(m))) begin
            mon_in = mon_in + 4'd1;
         end
      end
   end

   assign day_full = doy_d_ff - ecc_pkg::month_start(leap_ff, mon_in) + 9'd1;

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_E]) begin
         sec_e_ff  <= sec_d_ff;
         min_e_ff  <= min_d_ff;
         hour_e_ff <= hour_d_ff;
         mday_e_ff <= day_full[4:0];
         mon_e_ff  <= mon_in;
         year_e_ff <= year_d_ff;
         wk_e_ff   <= wk_d_ff;
         doy_e_ff  <= doy_d_ff;
      end
   end

   assign second       = sec_e_ff;
   assign minute       = min_e_ff;
   assign hour         = hour_e_ff;
   assign day_of_month = mday_e_ff;
   assign month        = mon_e_ff;
   assign year         = year_e_ff;
   assign weekday      = wk_e_ff;
   assign day_of_year  = doy_e_ff;

endmodule

`default_nettype wire

>>> rtl/ecc_build.sv
// ----------------------------------------------------------------------------
// ecc_build - calendar fields to seconds count datapath
// Five stages: checks and partial day counts, day total, minute total,
// seconds total, error masking.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_build (
   input  logic                   clock,
   input  ecc_pkg::pipe_ctrl_type ctrl,
   input  logic [7:0]             year_in,
   input  logic [3:0]             month_in,
   input  logic [4:0]             day_in,
   input  logic [4:0]             hour_in,
   input  logic [5:0]             minute_in,
   output logic                   error,
   output logic [31:0]            epoch_out
);

   // Stage A: range checks, days to the year and to the month
   logic [7:0]  yr_rel;
   logic        leap_a;
   logic [4:0]  mlen;
   logic        err_a_in;
   logic [14:0] ybase_in, ybase_ff;
   logic [8:0]  moff_in, moff_ff;
   logic [4:0]  hour_a_ff;
   logic [5:0]  min_a_ff;
   logic        err_a_ff;

   assign yr_rel   = year_in - ecc_pkg::EPOCH_YEAR;
   assign leap_a   = (yr_rel[1:0] == 2'd2);
   assign mlen     = ecc_pkg::month_len(leap_a, month_in);
   assign err_a_in = (year_in < ecc_pkg::EPOCH_YEAR) || (year_in > ecc_pkg::LAST_YEAR) ||
                     (month_in > ecc_pkg::LAST_MONTH) || (hour_in > ecc_pkg::LAST_HOUR) ||
                     (minute_in > ecc_pkg::LAST_MINUTE) || (day_in == 5'd0) ||
                     (day_in > mlen);
   assign ybase_in = ({10'd0, yr_rel[6:2]} * {4'd0, ecc_pkg::DAYS_PER_QUAD}) +
                     {4'd0, ecc_pkg::year_offset(yr_rel[1:0])};
   assign moff_in  = ecc_pkg::month_start(leap_a, month_in) + {4'd0, day_in} - 9'd1;

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_A]) begin
         err_a_ff  <= err_a_in;
         ybase_ff  <= ybase_in;
         moff_ff   <= moff_in;
         hour_a_ff <= hour_in;
         min_a_ff  <= minute_in;
      end
   end

   // Stage B: day total and minute of day
   logic [10:0] hour_mins;
   logic [14:0] days_ff;
   logic [10:0] hm_ff;
   logic        err_b_ff;

   assign hour_mins = {6'd0, hour_a_ff} * {5'd0, ecc_pkg::SIXTY};

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_B]) begin
         err_b_ff <= err_a_ff;
         days_ff  <= ybase_ff + {6'd0, moff_ff};
         hm_ff    <= hour_mins + {5'd0, min_a_ff};
      end
   end

   // Stage C: minute total
   logic [25:0] day_mins;
   logic [25:0] mtot_ff;
   logic        err_c_ff;

   assign day_mins = {11'd0, days_ff} * {15'd0, ecc_pkg::MINS_PER_DAY};

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_C]) begin
         err_c_ff <= err_b_ff;
         mtot_ff  <= day_mins + {15'd0, hm_ff};
      end
   end

   // Stage D: seconds total
   logic [31:0] secs_tot;
   logic [31:0] secs_ff;
   logic        err_d_ff;

   assign secs_tot = {6'd0, mtot_ff} * {26'd0, ecc_pkg::SIXTY};

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_D]) begin
         err_d_ff <= err_c_ff;
         secs_ff  <= secs_tot;
      end
   end

   // Stage E: drop the count on an invalid date
   logic [31:0] epoch_e_ff;
   logic        err_e_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[ecc_pkg::ST_E]) begin
         err_e_ff   <= err_d_ff;
         epoch_e_ff <= err_d_ff ? 32'd0 : secs_ff;
      end
   end

   assign error     = err_e_ff;
   assign epoch_out = epoch_e_ff;

endmodule

`default_nettype wire

>>> rtl/epoch_calendar_converter_top.sv
// ----------------------------------------------------------------------------
// epoch_calendar_converter_top - seconds count / calendar converter
// Converts a 32-bit seconds count from 1970 to calendar fields (func 0) or
// calendar fields to a seconds count (func 1), every fourth year a leap year.
//
// Channels: req_chan takes one conversion per transaction, rsp_chan returns
// one result per request, in order. With func 0 error and epoch_out read 0;
// with func 1 the calendar fields read 0 and an invalid date sets error with
// epoch_out 0.
// Latency: five register stages, A to E; the response is valid once the
// request has reached stage E, the output register.
// Throughput: one transaction per cycle unless stalled; the multiplies by
// the day, group, minute and hour reciprocals span the first three stages.
// Stall: while rsp_chan.ready is low the full stages ahead of any bubble
// hold; the rest move up, so req_chan.ready stays high until all five are full.
// Reset: synchronous, clears all stage valid bits; the block accepts
// requests in the first cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_calendar_converter_top (
   input  logic      clock,
   input  logic      reset,
   ecc_req_if.sink   req_chan,
   ecc_rsp_if.source rsp_chan
);

   ecc_pkg::pipe_ctrl_type ctrl;
   logic                   out_func;
   logic                   build_error;
   logic [31:0]            build_epoch;
   logic [5:0]             split_second;
   logic [5:0]             split_minute;
   logic [4:0]             split_hour;
   logic [4:0]             split_mday;
   logic [3:0]             split_month;
   logic [7:0]             split_year;
   logic [2:0]             split_weekday;
   logic [8:0]             split_doy;

   // Valid chain and stage enables
   ecc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_func   (req_chan.func),
      .out_ready (rsp_chan.ready),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_func  (out_func),
      .ctrl      (ctrl)
   );

   // Seconds to calendar
   ecc_split u_split (
      .clock         (clock),
      .ctrl          (ctrl),
      .epoch_seconds (req_chan.epoch_seconds),
      .second        (split_second),
      .minute        (split_minute),
      .hour          (split_hour),
      .day_of_month  (split_mday),
      .month         (split_month),
      .year          (split_year),
      .weekday       (split_weekday),
      .day_of_year   (split_doy)
   );

   // Calendar to seconds
   ecc_build u_build (
      .clock     (clock),
      .ctrl      (ctrl),
      .year_in   (req_chan.year_in),
      .month_in  (req_chan.month_in),
      .day_in    (req_chan.day_in),
      .hour_in   (req_chan.hour_in),
      .minute_in (req_chan.minute_in),
      .error     (build_error),
      .epoch_out (build_epoch)
   );

   // Zero the fields of the direction not taken
   assign rsp_chan.error        = out_func & build_error;
   assign rsp_chan.epoch_out    = out_func ? build_epoch : 32'd0;
   assign rsp_chan.second       = out_func ? 6'd0 : split_second;
   assign rsp_chan.minute       = out_func ? 6'd0 : split_minute;
   assign rsp_chan.hour         = out_func ? 5'd0 : split_hour;
   assign rsp_chan.day_of_month = out_func ? 5'd0 : split_mday;
   assign rsp_chan.month        = out_func ? 4'd0 : split_month;
   assign rsp_chan.year         = out_func ? 8'd0 : split_year;
   assign rsp_chan.weekday      = out_func ? 3'd0 : split_weekday;
   assign rsp_chan.day_of_year  = out_func ? 9'd0 : split_doy;

endmodule

`default_nettype wire
